>>> rtl/token_race_tracker_core_assert.svh
// ----------------------------------------------------------------------------
// Token race tracker assertion macros
// Shared forms for the concurrent checks on the tracker ports.
// ----------------------------------------------------------------------------
`ifndef TOKEN_RACE_TRACKER_CORE_ASSERT_SVH
`define TOKEN_RACE_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TRT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define TRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/trt_pkg.sv
// ----------------------------------------------------------------------------
// Token race tracker package
// Table size, request and status codes, payload and state types.
// ----------------------------------------------------------------------------
package trt_pkg;

   // Number of file entries in the table
   localparam int TABLE_DEPTH = 16;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);

   typedef logic [SLOT_W-1:0] slot_idx_type;

   // Request codes
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_END   = 2'd1;
   localparam logic [1:0] REQ_RACE  = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] fid_volume;
      logic [31:0] fid_vnode;
      logic [31:0] fid_unique;
      logic [15:0] call_race_mark;
      logic [63:0] token_type;
      logic [63:0] race_rights;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] race_mark;
      logic [63:0] token_type_out;
      logic        entry_found;
   } rsp_payload_type;

   // One table entry
   typedef struct packed {
      logic [63:0] volume;
      logic [31:0] vnode;
      logic [31:0] uniq;
      logic [15:0] active;
      logic [15:0] races;
      logic [63:0] rights;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

>>> rtl/token_race_tracker_core.sv
// ----------------------------------------------------------------------------
// Token race tracker core
// Keyed file-entry table that counts token revoke races per file id.
// ----------------------------------------------------------------------------
// One item is handled at a time. After an item is accepted, a single 128-bit
// key comparator steps through the table one slot per cycle, stopping at the
// first matching slot; a miss walks all TABLE_DEPTH slots to find the lowest
// free one. The update state then writes the entry and loads the result
// register, waiting there while a stalled result register has not drained.
// A new item is taken as soon as the previous one has been handed to the
// result register, even while that result is still stalled.
module token_race_tracker_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  trt_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output trt_pkg::rsp_payload_type rsp_data
);

   trt_pkg::state_type       state_ff, state_in;
   trt_pkg::req_payload_type item_ff, item_in;
   trt_pkg::slot_idx_type    scan_idx_ff, scan_idx_in;
   logic                     hit_ff, hit_in;
   trt_pkg::slot_idx_type    hit_idx_ff, hit_idx_in;
   logic                     free_ff, free_in;
   trt_pkg::slot_idx_type    free_idx_ff, free_idx_in;

   logic [trt_pkg::TABLE_DEPTH-1:0] valid_ff, valid_in;
   trt_pkg::slot_type               slot_ff [trt_pkg::TABLE_DEPTH];

   logic                     rsp_valid_ff, rsp_valid_in;
   trt_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  commit;
   logic                  scan_last;
   trt_pkg::slot_idx_type sel_idx;
   trt_pkg::slot_idx_type rd_idx;
   trt_pkg::slot_type     rd_slot;
   logic                  rd_valid;
   logic                  key_match;
   logic                  slot_we;
   trt_pkg::slot_type     slot_wdata;
   logic                  valid_we;
   logic                  valid_wval;
   logic [15:0]           active_dec;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != trt_pkg::ST_IDLE);
   assign commit    = (state_ff == trt_pkg::ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign scan_last = (scan_idx_ff == trt_pkg::slot_idx_type'(trt_pkg::TABLE_DEPTH - 1));

   // Single read port: scan address while searching, chosen slot while updating
   assign sel_idx  = hit_ff ? hit_idx_ff : free_idx_ff;
   assign rd_idx   = (state_ff == trt_pkg::ST_SCAN) ? scan_idx_ff : sel_idx;
   assign rd_slot  = slot_ff[rd_idx];
   assign rd_valid = valid_ff[rd_idx];

   // Shared key comparator
   assign key_match = rd_valid
                   && (rd_slot.volume == item_ff.fid_volume)
                   && (rd_slot.vnode  == item_ff.fid_vnode)
                   && (rd_slot.uniq   == item_ff.fid_unique);

   assign active_dec = rd_slot.active - 16'd1;

   // Sequencer: capture item, scan slots, update
   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      scan_idx_in = scan_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      case (state_ff)
         trt_pkg::ST_IDLE: begin
            if (accept) begin
               item_in     = req_data;
               scan_idx_in = '0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               state_in    = trt_pkg::ST_SCAN;
            end
         end
         trt_pkg::ST_SCAN: begin
            if (key_match) begin
               hit_in     = 1'b1;
               hit_idx_in = scan_idx_ff;
               state_in   = trt_pkg::ST_UPDATE;
            end else begin
               // remember the lowest free slot
               if (!rd_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = scan_idx_ff;
               end
               if (scan_last) begin
                  state_in = trt_pkg::ST_UPDATE;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
         end
         trt_pkg::ST_UPDATE: begin
            if (commit) begin
               state_in = trt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = trt_pkg::ST_IDLE;
         end
      endcase
   end

   // Entry update and result for the scanned item
   always_comb begin
      rsp_data_in = '0;
      slot_we     = 1'b0;
      slot_wdata  = rd_slot;
      valid_we    = 1'b0;
      valid_wval  = 1'b0;
      case (item_ff.req_type)
         trt_pkg::REQ_START: begin
            if (hit_ff) begin
               rsp_data_in.entry_found = 1'b1;
               rsp_data_in.race_mark   = rd_slot.races;
               slot_wdata.active       = rd_slot.active + 16'd1;
               slot_we                 = 1'b1;
            end else if (free_ff) begin
               slot_wdata.volume = item_ff.fid_volume;
               slot_wdata.vnode  = item_ff.fid_vnode;
               slot_wdata.uniq   = item_ff.fid_unique;
               slot_wdata.active = 16'd1;
               slot_wdata.races  = 16'd0;
               slot_wdata.rights = 64'd0;
               slot_we           = 1'b1;
               valid_we          = 1'b1;
               valid_wval        = 1'b1;
            end else begin
               rsp_data_in.status = trt_pkg::STAT_FULL;
            end
         end
         trt_pkg::REQ_END: begin
            rsp_data_in.token_type_out = item_ff.token_type;
            if (hit_ff) begin
               rsp_data_in.entry_found = 1'b1;
               // drop racing rights if a race was registered since start
               if (item_ff.call_race_mark != rd_slot.races) begin
                  rsp_data_in.token_type_out = item_ff.token_type & ~rd_slot.rights;
               end
               slot_wdata.active = active_dec;
               slot_we           = 1'b1;
               if (active_dec == 16'd0) begin
                  valid_we   = 1'b1;
                  valid_wval = 1'b0;
               end
            end else begin
               rsp_data_in.status = trt_pkg::STAT_NOT_FOUND;
            end
         end
         trt_pkg::REQ_RACE: begin
            if (hit_ff) begin
               rsp_data_in.entry_found = 1'b1;
               slot_wdata.rights       = rd_slot.rights | item_ff.race_rights;
               slot_wdata.races        = rd_slot.races + 16'd1;
               slot_we                 = 1'b1;
            end
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   // Valid bits
   always_comb begin
      valid_in = valid_ff;
      if (commit && valid_we) begin
         valid_in[sel_idx] = valid_wval;
      end
   end

   // Result handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trt_pkg::ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Table storage
   always_ff @(posedge clock) begin
      if (commit && slot_we) begin
         slot_ff[sel_idx] <= slot_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/trt_checker.sv
// ----------------------------------------------------------------------------
// Token race tracker checker
// Port-level checks on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "token_race_tracker_core_assert.svh"

module trt_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input trt_pkg::rsp_payload_type rsp_data
);

   // A stalled result holds
   `TRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled result item changed")

   // The block is busy right after it takes an item
   `TRT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall,
      req_stall, "input not stalled after accept")

   // A full table reports nothing else
   `TRT_ASSERT_IMPLY(a_full_clean, clock, reset,
      rsp_valid && (rsp_data.status == trt_pkg::STAT_FULL),
      (rsp_data.race_mark == 16'd0) && (rsp_data.token_type_out == 64'd0)
         && !rsp_data.entry_found,
      "table-full result carries data")

   // A found entry never comes with an error status
   `TRT_ASSERT_IMPLY(a_found_ok, clock, reset, rsp_valid && rsp_data.entry_found,
      rsp_data.status == trt_pkg::STAT_OK, "found entry with error status")

   // The start-only race mark stays clear on results without a found entry
   `TRT_ASSERT_IMPLY(a_mark_only_found, clock, reset, rsp_valid && !rsp_data.entry_found,
      rsp_data.race_mark == 16'd0, "race mark without a found entry")

endmodule

bind token_race_tracker_core trt_checker u_trt_checker (.*);
